@@ design/mssc_pkg.sv @@
// Shared types, command codes and register indexes of the seven-segment scanner.
package mssc_pkg;

	localparam logic [1:0] CMD_REFRESH = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_TOGGLE  = 2'd2;
	localparam logic [1:0] CMD_CLEAR   = 2'd3;

	localparam logic [1:0] REG_DIGIT_COUNT  = 2'd0;
	localparam logic [1:0] REG_FLASH_FIRST  = 2'd1;
	localparam logic [1:0] REG_FLASH_LAST   = 2'd2;
	localparam logic [1:0] REG_FLASH_PERIOD = 2'd3;

	localparam logic [3:0]  DIGIT_COUNT_RESET = 4'd8;
	localparam logic [7:0]  SEG_BLANK         = 8'h00;
	localparam logic [7:0]  SEG_POINT         = 8'h80;

	typedef struct packed {
		logic [1:0] command;
		logic [2:0] position;
		logic [2:0] range_last;
		logic [3:0] bcd_value;
		logic       last_digit;
	} in_item_t;

	typedef struct packed {
		logic [2:0] digit_select;
		logic [7:0] segments;
	} out_item_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic emit;
	} dp_ctrl_t;

	// Datapath status back to the controller.
	typedef struct packed {
		logic is_refresh;
	} dp_stat_t;

	function automatic logic [7:0] bcd_to_seg(input logic [3:0] bcd);
		logic [7:0] seg;
		case (bcd)
			4'd0:    seg = 8'h3F;
			4'd1:    seg = 8'h06;
			4'd2:    seg = 8'h5B;
			4'd3:    seg = 8'h4F;
			4'd4:    seg = 8'h66;
			4'd5:    seg = 8'h6D;
			4'd6:    seg = 8'h7D;
			4'd7:    seg = 8'h07;
			4'd8:    seg = 8'h7F;
			4'd9:    seg = 8'h6F;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

endpackage

@@ design/multiplexed_seven_segment_scanner_core.sv @@
// Top level of the multiplexed seven-segment display scanner.
// A command is taken when start is high and busy is low. A write, toggle or clear
// command keeps busy high in the execute state and returns nothing; a refresh tick
// keeps it high in the execute and emit states (update scan and flash state, then
// read the segment memory), and its result appears on the result port with strobe
// high for exactly one cycle, the first cycle busy is low. The receiver cannot stall,
// so a result must be captured in the cycle its strobe is high. Registers must be written
// through the APB port only while the block is idle (not enforced); pready is always high.
module multiplexed_seven_segment_scanner_core #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mssc_pkg::in_item_t  item,
	output logic                strobe,
	output mssc_pkg::out_item_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import mssc_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	assign pready = 1'b1;

	mssc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.strobe (strobe),
		.ctrl   (ctrl),
		.stat   (stat)
	);

	mssc_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.result  (result),
		.ctrl    (ctrl),
		.stat    (stat),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata)
	);

endmodule

@@ design/mssc_ctrl.sv @@
// Controller state machine of the seven-segment scanner.
module mssc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              strobe,
	output mssc_pkg::dp_ctrl_t ctrl,
	input  mssc_pkg::dp_stat_t stat
);
	import mssc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_EMIT);
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= stat.is_refresh ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign ctrl.load = start && (state_q == ST_IDLE);
	assign ctrl.exec = (state_q == ST_EXEC);
	assign ctrl.emit = (state_q == ST_EMIT);

endmodule

@@ design/mssc_dp.sv @@
// Datapath of the seven-segment scanner: registers, segment memory, scan and flash logic.
module mssc_dp #(
	parameter int MAX_DIGITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mssc_pkg::in_item_t item,
	output mssc_pkg::out_item_t result,
	input  mssc_pkg::dp_ctrl_t ctrl,
	output mssc_pkg::dp_stat_t stat,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata
);
	import mssc_pkg::*;

	localparam int SCAN_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [4:0] MAX_N   = 5'(MAX_DIGITS);
	localparam logic [4:0] MAX_IDX = 5'(MAX_DIGITS - 1);

	in_item_t          item_q;
	out_item_t         result_q;
	logic [7:0]        mem_q [MAX_DIGITS];
	logic [SCAN_W-1:0] scan_q;
	logic [15:0]       flash_cnt_q;
	logic [3:0]        digit_count_q;
	logic [2:0]        flash_first_q;
	logic [2:0]        flash_last_q;
	logic [15:0]       flash_period_q;

	logic        cfg_wr;
	logic [1:0]  cfg_idx;
	logic [4:0]  eff_n;
	logic [4:0]  eff_n_new;
	logic [4:0]  scan_ext;
	logic [4:0]  scan_inc;
	logic [4:0]  scan_next;
	logic [15:0] cnt_inc;
	logic [4:0]  pos_ext;
	logic [4:0]  tog_end;
	logic [7:0]  cur_seg;
	logic        blank;

	// Digit count clamped to the range one to the memory depth.
	function automatic logic [4:0] eff_count(input logic [3:0] dc);
		logic [4:0] n;
		n = {1'b0, dc};
		if (n == 5'd0) n = 5'd1;
		if (n > MAX_N) n = MAX_N;
		return n;
	endfunction

	assign cfg_wr    = psel && penable && pwrite;
	assign cfg_idx   = paddr[3:2];
	assign eff_n     = eff_count(digit_count_q);
	assign eff_n_new = eff_count(pwdata[3:0]);
	assign scan_ext  = 5'(scan_q);
	assign scan_inc  = scan_ext + 5'd1;
	assign scan_next = (scan_inc >= eff_n) ? 5'd0 : scan_inc;
	assign cnt_inc   = flash_cnt_q + 16'd1;
	assign pos_ext   = {2'b00, item_q.position};
	assign tog_end   = ({2'b00, item_q.range_last} > MAX_IDX) ? MAX_IDX
	                                                          : {2'b00, item_q.range_last};
	assign cur_seg   = mem_q[scan_q];
	assign blank     = (flash_period_q != 16'd0)
	                && (flash_cnt_q >= {1'b0, flash_period_q[15:1]})
	                && (scan_ext >= {2'b00, flash_first_q})
	                && (scan_ext <= {2'b00, flash_last_q});

	// Configuration registers and the scan and flash state, which refresh ticks advance and register writes reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q  <= DIGIT_COUNT_RESET;
			flash_first_q  <= 3'd0;
			flash_last_q   <= 3'd0;
			flash_period_q <= 16'd0;
			flash_cnt_q    <= 16'd0;
			scan_q         <= SCAN_W'(eff_count(DIGIT_COUNT_RESET) - 5'd1);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DIGIT_COUNT: begin
					digit_count_q <= pwdata[3:0];
					scan_q        <= SCAN_W'(eff_n_new - 5'd1);
				end
				REG_FLASH_FIRST:  flash_first_q <= pwdata[2:0];
				REG_FLASH_LAST:   flash_last_q  <= pwdata[2:0];
				REG_FLASH_PERIOD: begin
					flash_period_q <= pwdata[15:0];
					flash_cnt_q    <= 16'd0;
				end
				default: ;
			endcase
		end else if (ctrl.exec && item_q.command == CMD_REFRESH) begin
			scan_q <= SCAN_W'(scan_next);
			// A wrap to the first digit ends a scan frame.
			if (scan_next == 5'd0) begin
				flash_cnt_q <= (cnt_inc >= flash_period_q) ? 16'd0 : cnt_inc;
			end
		end
	end

	// Segment memory: each entry decides its own update in parallel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGITS; i++) mem_q[i] <= SEG_BLANK;
		end else if (ctrl.exec) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				case (item_q.command)
					CMD_WRITE: begin
						if (5'(i) == pos_ext && pos_ext < eff_n) begin
							mem_q[i] <= bcd_to_seg(item_q.bcd_value);
						end else if (item_q.last_digit && 5'(i) > pos_ext) begin
							mem_q[i] <= SEG_BLANK;
						end
					end
					CMD_TOGGLE: begin
						if (5'(i) >= pos_ext && 5'(i) <= tog_end) begin
							mem_q[i] <= mem_q[i] ^ SEG_POINT;
						end
					end
					CMD_CLEAR: mem_q[i] <= SEG_BLANK;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) item_q <= item;
		if (ctrl.emit) begin
			result_q.digit_select <= scan_ext[2:0];
			result_q.segments     <= blank ? SEG_BLANK : cur_seg;
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_DIGIT_COUNT:  prdata = {28'd0, digit_count_q};
			REG_FLASH_FIRST:  prdata = {29'd0, flash_first_q};
			REG_FLASH_LAST:   prdata = {29'd0, flash_last_q};
			REG_FLASH_PERIOD: prdata = {16'd0, flash_period_q};
			default:          prdata = 32'd0;
		endcase
	end

	assign stat.is_refresh = (item_q.command == CMD_REFRESH);
	assign result          = result_q;

endmodule
